>>> hdl/chd_pkg.sv
// Shared types, constants and hash/compare helpers for the chained hash
// name directory. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package chd_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_LOOKUP = 2'd2;

  localparam int          NAME_CHARS = 8;
  localparam int          NAME_W     = 64;
  localparam int          BC_W       = 13;
  localparam int          IDX_OUT_W  = 12;
  localparam logic [31:0] HASH_SEED  = 32'd1315423911;
  localparam logic [BC_W-1:0] BC_RESET = 13'd4096;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_DIV,
    F_OUT
  } front_state_t;

  typedef enum logic [2:0] {
    B_SWEEP,
    B_IDLE,
    B_INS,
    B_LK_HEAD,
    B_LK_CMP
  } back_state_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
    return h ^ ((h << 5) + {24'd0, fold_case(c)} + (h >> 2));
  endfunction

  function automatic logic names_match(input logic [NAME_W-1:0] a,
                                       input logic [NAME_W-1:0] b);
    logic       ok;
    logic       done;
    logic [7:0] x;
    logic [7:0] y;
    ok   = 1'b1;
    done = 1'b0;
    for (int k = 0; k < NAME_CHARS; k++) begin
      x = fold_case(a[8*k +: 8]);
      y = fold_case(b[8*k +: 8]);
      if (!done) begin
        if (x != y) begin
          ok   = 1'b0;
          done = 1'b1;
        end else if (x == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

>>> hdl/chd_front.sv
// Front end: accepts words, hashes the name one character a cycle and
// reduces the hash modulo the bucket count bit-serially. Uses chd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chd_front #(
  parameter int MAX_ENTRIES = 4096,
  parameter int IW = $clog2(MAX_ENTRIES)
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  chd_pkg::op_t          in_op,
  input  wire  [chd_pkg::NAME_W-1:0]  in_name,
  input  wire  [chd_pkg::BC_W-1:0]    bucket_count,
  output logic                        q_push,
  input  wire                         q_full,
  output chd_pkg::op_t                q_op,
  output logic [chd_pkg::NAME_W-1:0]  q_name,
  output logic [IW-1:0]               q_bucket
);
  import chd_pkg::*;

  front_state_t      state, state_next;
  op_t               op;
  logic [NAME_W-1:0] name;
  logic [31:0]       h;
  logic [2:0]        k;
  logic [4:0]        cnt;
  logic [BC_W:0]     rem;
  logic [BC_W-1:0]   nb;
  logic [BC_W:0]     trial;
  logic [7:0]        c;

  always_comb begin
    if (bucket_count == '0) begin
      nb = BC_W'(1);
    end else if (32'(bucket_count) > 32'(MAX_ENTRIES)) begin
      nb = BC_W'(MAX_ENTRIES);
    end else begin
      nb = bucket_count;
    end
  end

  assign c     = name[8*k +: 8];
  assign trial = {rem[BC_W-1:0], h[31]};

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    q_push     = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (in_op == OP_INSERT || in_op == OP_LOOKUP) ? F_HASH : F_OUT;
        end
      end
      F_HASH: begin
        if (c == 8'd0 || k == 3'd7) begin
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        if (cnt == 5'd31) begin
          state_next = F_OUT;
        end
      end
      F_OUT: begin
        q_push = !q_full;
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        op   <= in_op;
        name <= in_name;
        h    <= HASH_SEED;
        k    <= 3'd0;
        rem  <= '0;
        cnt  <= 5'd0;
      end
      F_HASH: begin
        if (c != 8'd0) begin
          h <= hash_step(h, c);
        end
        k <= k + 3'd1;
      end
      F_DIV: begin
        h   <= h << 1;
        cnt <= cnt + 5'd1;
        if (trial >= {1'b0, nb}) begin
          rem <= trial - {1'b0, nb};
        end else begin
          rem <= trial;
        end
      end
      default: begin
      end
    endcase
  end

  assign q_op     = op;
  assign q_name   = name;
  assign q_bucket = IW'(rem);

endmodule
`default_nettype wire

>>> hdl/chd_queue.sv
// Two-entry queue between front and back ends. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module chd_queue #(
  parameter int DW = 8
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  wire  [DW-1:0] wdata,
  output logic          full,
  input  wire           pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);
  logic [DW-1:0] slot [2];
  logic          wp, rp;
  logic [1:0]    fill;

  assign full  = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign rdata = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> hdl/chd_back.sv
// Back end: bucket heads, name store and chain links; runs insert, lookup
// chain walk and the clearing sweep. Uses chd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chd_back #(
  parameter int MAX_ENTRIES = 4096,
  parameter int IW = $clog2(MAX_ENTRIES)
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         q_empty,
  output logic                        q_pop,
  input  wire  chd_pkg::op_t          q_op,
  input  wire  [chd_pkg::NAME_W-1:0]  q_name,
  input  wire  [IW-1:0]               q_bucket,
  output logic                        sweeping,
  output logic                        res_valid,
  input  wire                         res_pop,
  output logic                        res_found,
  output logic [IW-1:0]               res_idx,
  output logic                        res_full
);
  import chd_pkg::*;

  back_state_t       state, state_next;
  logic [IW:0]       head_mem [MAX_ENTRIES];
  logic [IW:0]       link_mem [MAX_ENTRIES];
  logic [NAME_W-1:0] name_mem [MAX_ENTRIES];
  logic [IW:0]       head_q, link_q;
  logic [NAME_W-1:0] name_q;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     sweep;
  logic [IW:0]       count;
  logic [IW-1:0]     cur;
  logic [IW-1:0]     bucket;
  logic [NAME_W-1:0] name;
  logic              take;
  logic              res_set, found_next, full_next;
  logic [IW-1:0]     idx_next;
  logic              is_full;

  assign is_full  = count >= (IW+1)'(MAX_ENTRIES);
  assign sweeping = state == B_SWEEP;
  assign take     = !q_empty && (!res_valid || res_pop);
  assign q_pop    = state == B_IDLE && take;

  always_comb begin
    state_next = state;
    res_set    = 1'b0;
    found_next = 1'b0;
    full_next  = 1'b0;
    idx_next   = '0;
    rd_addr    = link_q[IW-1:0];
    unique case (state)
      B_SWEEP: begin
        if (sweep == IW'(MAX_ENTRIES - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (take) begin
          case (q_op)
            OP_CLEAR: begin
              res_set    = 1'b1;
              state_next = B_SWEEP;
            end
            OP_INSERT: begin
              if (is_full) begin
                res_set   = 1'b1;
                full_next = 1'b1;
              end else begin
                state_next = B_INS;
              end
            end
            OP_LOOKUP: state_next = B_LK_HEAD;
            default:   res_set = 1'b1;
          endcase
        end
      end
      B_INS: begin
        res_set    = 1'b1;
        found_next = 1'b1;
        idx_next   = count[IW-1:0];
        state_next = B_IDLE;
      end
      B_LK_HEAD: begin
        rd_addr = head_q[IW-1:0];
        if (!head_q[IW]) begin
          res_set    = 1'b1;
          state_next = B_IDLE;
        end else begin
          state_next = B_LK_CMP;
        end
      end
      B_LK_CMP: begin
        if (names_match(name_q, name)) begin
          res_set    = 1'b1;
          found_next = 1'b1;
          idx_next   = cur;
          state_next = B_IDLE;
        end else if (!link_q[IW]) begin
          res_set    = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_SWEEP;
      sweep     <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_SWEEP) begin
        sweep <= sweep + IW'(1);
      end else begin
        sweep <= '0;
      end
      if (state == B_IDLE && take && q_op == OP_CLEAR) begin
        count <= '0;
      end else if (state == B_INS) begin
        count <= count + (IW+1)'(1);
      end
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      res_found <= found_next;
      res_idx   <= idx_next;
      res_full  <= full_next;
    end
    if (q_pop) begin
      name   <= q_name;
      bucket <= q_bucket;
    end
    if (state == B_LK_HEAD || state == B_LK_CMP) begin
      cur <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_SWEEP) begin
      head_mem[sweep] <= '0;
    end else if (state == B_INS) begin
      head_mem[bucket] <= {1'b1, count[IW-1:0]};
    end
    head_q <= head_mem[q_bucket];
  end

  always_ff @(posedge clk) begin
    if (state == B_INS) begin
      name_mem[count[IW-1:0]] <= name;
      link_mem[count[IW-1:0]] <= head_q;
    end
    name_q <= name_mem[rd_addr];
    link_q <= link_mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hdl/chained_hash_name_directory.sv
// Top level of the chained hash name directory: config register, front end,
// queue and back end. Uses chd_pkg, chd_front, chd_queue, chd_back.
//
// An insert or lookup holds the front end through acceptance, the hash of
// each name character up to the terminating zero (eight at most), the
// bit-serial modulo by the bucket count and the hand-off to the queue,
// which waits while the queue is full. Clear and an undefined op skip the
// hash and modulo. The back end then runs an insert in its insert state and
// a lookup by a head read and a compare of each chain entry visited. Clear
// and the post-reset sweep walk every bucket head, with full held high.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_name_directory #(
  parameter int MAX_ENTRIES = 4096
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire  [chd_pkg::BC_W-1:0]    cfg_wdata,
  input  wire                         push,
  output logic                        full,
  input  wire  chd_pkg::op_t          op,
  input  wire  [chd_pkg::NAME_W-1:0]  name,
  output logic                        empty,
  input  wire                         pop,
  output logic                        found,
  output logic [chd_pkg::IDX_OUT_W-1:0] entry_index,
  output logic                        table_full
);
  import chd_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int QW = 2 + NAME_W + IW;

  logic [BC_W-1:0]   bucket_count;
  logic              in_ready, sweeping;
  logic              f_push, q_full, q_empty, q_pop;
  op_t               f_op, b_op;
  logic [NAME_W-1:0] f_name, b_name;
  logic [IW-1:0]     f_bucket, b_bucket, res_idx;
  logic [QW-1:0]     q_rdata;
  logic              res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BC_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  assign full = !in_ready || sweeping;

  chd_front #(.MAX_ENTRIES(MAX_ENTRIES), .IW(IW)) u_front (
    .clk, .rst,
    .in_valid(push && !sweeping), .in_ready,
    .in_op(op), .in_name(name), .bucket_count,
    .q_push(f_push), .q_full,
    .q_op(f_op), .q_name(f_name), .q_bucket(f_bucket)
  );

  chd_queue #(.DW(QW)) u_queue (
    .clk, .rst,
    .push(f_push), .wdata({f_op, f_name, f_bucket}), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  assign {b_op, b_name, b_bucket} = q_rdata;

  chd_back #(.MAX_ENTRIES(MAX_ENTRIES), .IW(IW)) u_back (
    .clk, .rst,
    .q_empty, .q_pop, .q_op(b_op), .q_name(b_name), .q_bucket(b_bucket),
    .sweeping, .res_valid, .res_pop(pop && !empty),
    .res_found(found), .res_idx, .res_full(table_full)
  );

  assign empty       = !res_valid;
  assign entry_index = IDX_OUT_W'(res_idx);

`ifndef SYNTHESIS
  a_busy_after_push: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full) else $error("accepted word did not raise full");
  a_found_xor_full: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(found && table_full)) else $error("found and table_full together");
  a_index_zero_miss: assert property (@(posedge clk) disable iff (rst)
    !empty && !found |-> entry_index == '0) else $error("index nonzero on miss");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(entry_index)) else $error("result word lost");
`endif

endmodule
`default_nettype wire
